FILE: rtl/bdg_pkg.sv
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared types, field widths and codes for the button debounce and gesture
// classifier.
// ----------------------------------------------------------------------------
package bdg_pkg;

   // Width of the internal time arithmetic; differences wrap at this width.
   localparam int TIME_BITS = 32;

   // Fixed field widths on the ports.
   localparam int NOW_W  = 32;
   localparam int CFG_W  = 16;
   localparam int CSR_IDX_W = 2;

   // Request tdata: level, now_time, then zero padding up to whole bytes.
   localparam int REQ_LEVEL_BIT = 0;
   localparam int REQ_NOW_LSB   = 1;
   localparam int REQ_USED_W    = 1 + NOW_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata: gesture, gesture_start, released, then zero padding.
   localparam int GEST_W         = 2;
   localparam int RSP_GEST_LSB   = 0;
   localparam int RSP_START_LSB  = GEST_W;
   localparam int RSP_REL_BIT    = GEST_W + NOW_W;
   localparam int RSP_USED_W     = GEST_W + NOW_W + 1;
   localparam int RSP_TDATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG     = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
   localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd300;
   localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;

   typedef enum logic [GEST_W-1:0] {
      GEST_NONE   = 2'd0,
      GEST_SHORT  = 2'd1,
      GEST_DOUBLE = 2'd2,
      GEST_LONG   = 2'd3
   } gesture_type;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] double_click_window;
      logic [CFG_W-1:0] long_press_time;
   } cfg_type;

   typedef struct packed {
      logic     kind;
      logic     level;
      time_type now_time;
   } item_type;

   typedef struct packed {
      logic     raw_now;
      logic     stable_now;
      time_type raw_change_time;
      logic     is_pressed;
      logic     long_done;
      logic     short_pending;
      logic     second_down;
      time_type press_start;
      time_type gesture_begin;
      time_type first_release;
      time_type emitted_begin;
   } state_type;

   localparam state_type STATE_RST = '{
      raw_now:         1'b1,
      stable_now:      1'b1,
      raw_change_time: '0,
      is_pressed:      1'b0,
      long_done:       1'b0,
      short_pending:   1'b0,
      second_down:     1'b0,
      press_start:     '0,
      gesture_begin:   '0,
      first_release:   '0,
      emitted_begin:   '0
   };

   // Modular time difference.
   function automatic time_type elapsed(input time_type now, input time_type then);
      return now - then;
   endfunction

endpackage

FILE: rtl/bdg_csr.sv
// ----------------------------------------------------------------------------
// bdg_csr
// Timing registers (debounce, double-click window, long press), written over
// the csr channel.
// ----------------------------------------------------------------------------
module bdg_csr
   import bdg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_time       = csr_data;
            CSR_WINDOW:   cfg_in.double_click_window = csr_data;
            CSR_LONG:     cfg_in.long_press_time     = csr_data;
            default:      cfg_in = cfg_ff;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time       <= DEBOUNCE_RST;
         cfg_ff.double_click_window <= WINDOW_RST;
         cfg_ff.long_press_time     <= LONG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/bdg_step.sv
// ----------------------------------------------------------------------------
// bdg_step
// Next-state and result logic for one item: init reload, or debounce, then
// press/release handling, then long-press and expired-short checks.
// ----------------------------------------------------------------------------
module bdg_step
   import bdg_pkg::*;
(
   input  state_type   state_cur,
   input  cfg_type     cfg,
   input  item_type    item,
   output state_type   state_next,
   output gesture_type gesture,
   output logic        released
);

   state_type   s;
   gesture_type g;
   time_type    deb;
   time_type    win;
   time_type    lpt;
   logic        accept;
   logic        in_window;

   assign deb = TIME_BITS'(cfg.debounce_time);
   assign win = TIME_BITS'(cfg.double_click_window);
   assign lpt = TIME_BITS'(cfg.long_press_time);

   always_comb begin
      s         = state_cur;
      g         = GEST_NONE;
      accept    = 1'b0;
      in_window = elapsed(item.now_time, state_cur.first_release) <= win;

      if (item.kind) begin
         // init: clear everything, load level and time; low level = held
         s                 = STATE_RST;
         s.raw_now         = item.level;
         s.stable_now      = item.level;
         s.raw_change_time = item.now_time;
         if (!item.level) begin
            s.is_pressed    = 1'b1;
            s.press_start   = item.now_time;
            s.gesture_begin = item.now_time;
         end
      end else begin
         if (item.level != s.raw_now) begin
            s.raw_now         = item.level;
            s.raw_change_time = item.now_time;
         end
         accept = (s.raw_now != s.stable_now) &&
                  (elapsed(item.now_time, s.raw_change_time) >= deb);

         if (accept) begin
            s.stable_now = s.raw_now;
            if (!s.raw_now) begin
               // press
               if (!state_cur.is_pressed) begin
                  if (state_cur.short_pending) begin
                     if (in_window) begin
                        s.second_down = 1'b1;
                     end else begin
                        // window ran out: the press itself flushes the short
                        s.short_pending = 1'b0;
                        g               = GEST_SHORT;
                        s.emitted_begin = state_cur.gesture_begin;
                     end
                  end
                  s.is_pressed  = 1'b1;
                  s.long_done   = 1'b0;
                  s.press_start = s.raw_change_time;
                  if (!s.second_down) begin
                     s.gesture_begin = s.raw_change_time;
                  end
               end
            end else begin
               // release
               if (state_cur.is_pressed) begin
                  s.is_pressed = 1'b0;
                  priority if (state_cur.long_done) begin
                     s.long_done = 1'b0;
                  end else if (state_cur.second_down) begin
                     s.short_pending = 1'b0;
                     s.second_down   = 1'b0;
                     s.emitted_begin = state_cur.gesture_begin;
                     g               = GEST_DOUBLE;
                  end else begin
                     s.short_pending = 1'b1;
                     s.first_release = item.now_time;
                  end
               end
            end
         end

         if (g == GEST_NONE && s.is_pressed && !s.long_done &&
             elapsed(item.now_time, s.press_start) >= lpt) begin
            s.long_done     = 1'b1;
            s.short_pending = 1'b0;
            s.second_down   = 1'b0;
            s.emitted_begin = s.gesture_begin;
            g               = GEST_LONG;
         end

         if (g == GEST_NONE && s.short_pending &&
             elapsed(item.now_time, s.first_release) > win) begin
            s.short_pending = 1'b0;
            s.second_down   = 1'b0;
            s.emitted_begin = s.gesture_begin;
            g               = GEST_SHORT;
         end
      end
   end

   assign state_next = s;
   assign gesture    = g;
   assign released   = s.raw_now && s.stable_now && !s.is_pressed;

endmodule

FILE: rtl/button_debounce_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_gesture_classifier
// Debounces timestamped active-low button samples and classifies short,
// double and long presses; one result per input item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_tvalid/req_tready | tuser: kind; tdata: level, now
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: gesture, start, released
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data (16 bit)
//
//  After the req transfer the item sits in the input register, then the step
//  logic loads the result register and rsp_tvalid rises. Throughput is one
//  item per clock while rsp is not stalled; the state update is a single pass
//  of a few parallel 32-bit subtract/compare paths.
//  Reset (synchronous) empties both registers and restores the timing
//  registers to 30 / 300 / 800 ms. csr_ready is always high.
//  An rsp stall holds the result; req_tready drops only while the input
//  register is full and the result register is stalled.
//
module button_debounce_gesture_classifier
   import bdg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] level, [32:1] now_time, zero pad
   input  logic                   req_tuser,   // [0] kind (1 = init)

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [1:0] gesture, [33:2] gesture_start,
                                               // [34] released, zero pad

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   cfg_type     cfg;

   // input register
   logic        in_valid_ff;
   item_type    in_item_ff;
   item_type    in_item_in;

   // block state
   state_type   state_ff;
   state_type   state_in;

   // result register
   logic        rsp_valid_ff;
   gesture_type gest_ff;
   gesture_type gest_in;
   time_type    start_ff;
   logic        released_ff;
   logic        released_in;

   logic        req_xfer;
   logic        advance;

   assign csr_ready = 1'b1;

   bdg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The held item moves on whenever the result register is free or drains.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_item_in.kind     = req_tuser;
   assign in_item_in.level    = req_tdata[REQ_LEVEL_BIT];
   assign in_item_in.now_time = TIME_BITS'(req_tdata[REQ_NOW_LSB +: NOW_W]);

   bdg_step u_step (
      .state_cur  (state_ff),
      .cfg        (cfg),
      .item       (in_item_ff),
      .state_next (state_in),
      .gesture    (gest_in),
      .released   (released_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RST;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         gest_ff     <= gest_in;
         start_ff    <= state_in.emitted_begin;
         released_ff <= released_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), released_ff,
                        NOW_W'(start_ff), gest_ff};

endmodule

FILE: rtl/bdg_checker.sv
// ----------------------------------------------------------------------------
// bdg_checker
// Port-level checks for the gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bdg_checker
   import bdg_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_IDX_W-1:0]   csr_index,
   input logic [CFG_W-1:0]       csr_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // after reset nothing is pending and the input side is open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // input back-pressure only comes from a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled result");

   // a long press is reported while the button is still held
   a_long_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_GEST_LSB +: GEST_W] == GEST_LONG)
      |-> !rsp_tdata[RSP_REL_BIT])
      else $error("long press reported as released");

   // the config port never pushes back
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind button_debounce_gesture_classifier bdg_checker u_bdg_checker (.*);
